@@ rtl/pes_pkg.sv @@
`default_nettype none
package pes_pkg;

  localparam int NUM_EVENTS = 32;
  localparam int MAX_READOUT = 32;
  localparam int READ_N = (NUM_EVENTS < MAX_READOUT) ? NUM_EVENTS : MAX_READOUT;
  localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

  // rounding divide of the square sum, one 16-bit digit per cycle
  localparam int SQ_DIV = 1000;
  localparam int SQ_HALF = 500;
  localparam int REM_W = 10;
  localparam int DIGIT_W = 16;
  localparam int PART_W = REM_W + DIGIT_W;
  localparam int SQ_SHIFT = 36;                 // exact quotient for any PART_W-bit dividend
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] SQ_RECIP = 27'd68719477;   // ceil(2^36 / 1000)
  localparam int PROD_W = PART_W + RECIP_W;
  localparam int DIV_ITERS = 64 / DIGIT_W;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_SOFT   = 2'd1;
  localparam logic [1:0] OP_HARD   = 2'd2;

  typedef struct packed {
    logic [31:0] success;
    logic [31:0] failure;
    logic [31:0] time_sum;
    logic [63:0] square;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_REC_WR,
    ST_FL_RD,
    ST_FL_CAP,
    ST_FL_DIV,
    ST_FL_OUT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/per_event_statistics_table.sv @@
// Record transaction: read entry and square the time, then add and write back.
// Flush, per entry: read, capture, rounding divide of the square sum, then the output
// state, which holds while out_stall is high; READ_N entries in all.
// One transaction is worked on at a time; in_stall is high until it is finished.
// Reset (synchronous) clears the touched flags at once; an untouched entry reads as zero,
// so no clearing pass over the RAM is needed. Hard flush clears the flags the same way.
`default_nettype none
module per_event_statistics_table
  import pes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [4:0]  event_kind,
  input  wire logic        failed,
  input  wire logic [31:0] elapsed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [4:0]  entry_kind,
  output logic             touched,
  output logic      [31:0] success_total,
  output logic      [31:0] failure_total,
  output logic      [31:0] time_total,
  output logic      [63:0] square_total_scaled,
  output logic             last_entry
);

  state_t state;
  state_t state_next;

  logic [NUM_EVENTS-1:0] touched_q;
  logic [IDX_W-1:0]      kind_q;
  logic                  failed_q;
  logic                  hard_q;
  logic [31:0]           elapsed_q;
  logic [63:0]           prod_q;
  entry_t                ent_q;
  entry_t                ent_new;
  logic [IDX_W-1:0]      idx;

  logic                  in_acc;
  logic                  out_acc;
  logic                  kind_ok;
  logic                  is_last;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  entry_t                rd_ent;
  logic                  scale_start;
  logic                  scale_done;
  logic [63:0]           scale_in;
  logic [63:0]           scale_res;
  logic [64:0]           sq_sum;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign kind_ok  = 32'(event_kind) < NUM_EVENTS;
  assign is_last  = idx == IDX_W'(READ_N - 1);
  assign rd_ent   = entry_t'(ram_rdata);
  // square sum straight from the RAM word being captured
  assign scale_in = touched_q[idx] ? rd_ent.square : 64'd0;

  pes_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_EVENTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(kind_q),
    .wdata(ENTRY_W'(ent_new)),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pes_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .value (scale_in),
    .done  (scale_done),
    .result(scale_res)
  );

  // updated entry for a record transaction
  always_comb begin
    sq_sum = {1'b0, ent_q.square} + {1'b0, prod_q};
    ent_new = ent_q;
    if (failed_q) begin
      ent_new.failure = ent_q.failure + 32'd1;
    end else begin
      ent_new.success  = ent_q.success + 32'd1;
      ent_new.time_sum = ent_q.time_sum + elapsed_q;
      ent_new.square   = sq_sum[64] ? '1 : sq_sum[63:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode == OP_RECORD && kind_ok) begin
            state_next = ST_REC_RD;
          end else if (opcode == OP_SOFT || opcode == OP_HARD) begin
            state_next = ST_FL_RD;
          end
        end
      end
      ST_REC_RD: state_next = ST_REC_WR;
      ST_REC_WR: state_next = ST_IDLE;
      ST_FL_RD:  state_next = ST_FL_CAP;
      ST_FL_CAP: state_next = ST_FL_DIV;
      ST_FL_DIV: begin
        if (scale_done) begin
          state_next = ST_FL_OUT;
        end
      end
      ST_FL_OUT: begin
        if (out_acc) begin
          state_next = is_last ? ST_IDLE : ST_FL_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    ram_we      = 1'b0;
    scale_start = 1'b0;
    ram_raddr   = idx;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = IDX_W'(event_kind);
      end
      ST_REC_RD: ram_raddr = kind_q;
      ST_REC_WR: ram_we = 1'b1;
      ST_FL_RD:  ram_raddr = idx;
      ST_FL_CAP: scale_start = 1'b1;
      ST_FL_DIV: ram_raddr = idx;
      ST_FL_OUT: out_valid = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      touched_q <= '0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_acc) begin
        idx <= '0;
      end
      if (state == ST_REC_WR) begin
        touched_q[kind_q] <= 1'b1;
      end
      if (state == ST_FL_OUT && out_acc) begin
        idx <= idx + 1'b1;
        if (is_last && hard_q) begin
          touched_q <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      kind_q    <= IDX_W'(event_kind);
      failed_q  <= failed;
      elapsed_q <= elapsed;
      hard_q    <= opcode == OP_HARD;
    end
    if (state == ST_REC_RD) begin
      prod_q <= elapsed_q * elapsed_q;
      ent_q  <= touched_q[kind_q] ? rd_ent : '0;
    end
    if (state == ST_FL_CAP) begin
      touched       <= touched_q[idx];
      success_total <= touched_q[idx] ? rd_ent.success : 32'd0;
      failure_total <= touched_q[idx] ? rd_ent.failure : 32'd0;
      time_total    <= touched_q[idx] ? rd_ent.time_sum : 32'd0;
      entry_kind    <= 5'(idx);
    end
    if (state == ST_FL_DIV && scale_done) begin
      square_total_scaled <= scale_res;
    end
  end

  assign last_entry = is_last;

endmodule
`default_nettype wire

@@ rtl/pes_ram.sv @@
`default_nettype none
module pes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/pes_scale.sv @@
`default_nettype none
module pes_scale
  import pes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] value,
  output logic             done,
  output logic      [63:0] result
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [63:0]          dvd;
  logic [63:0]          quo;
  logic [REM_W-1:0]     rem;
  logic [PART_W-1:0]    part;
  logic [PROD_W-1:0]    prod;
  logic [DIGIT_W-1:0]   qd;
  logic [PART_W-1:0]    back;
  logic [63:0]          dvd_next;
  logic [63:0]          quo_next;
  logic [REM_W-1:0]     rem_next;

  // long division by 16-bit digits; remainder and digit stay below 1000 * 2^16,
  // so the digit quotient comes from a reciprocal multiply
  always_comb begin
    part     = {rem, dvd[63 -: DIGIT_W]};
    prod     = PROD_W'(part) * PROD_W'(SQ_RECIP);
    qd       = prod[SQ_SHIFT +: DIGIT_W];
    back     = part - PART_W'(qd) * PART_W'(SQ_DIV);
    rem_next = back[REM_W-1:0];
    dvd_next = {dvd[63-DIGIT_W:0], {DIGIT_W{1'b0}}};
    quo_next = {quo[63-DIGIT_W:0], qd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= value;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // quotient cannot reach all ones, so the round-up never wraps
  assign result = quo + {63'd0, (rem >= REM_W'(SQ_HALF))};

endmodule
`default_nettype wire
